// ===== src/mrrf_pkg.sv =====
// shared types, constants and crc byte update for the read request framer
package mrrf_pkg;

    localparam logic [7:0]  FUNC_READ_INPUT  = 8'h04;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h02;
    localparam logic [2:0]  LAST_IDX         = 3'd7;

    typedef struct packed {
        logic [47:0] hdr;
        logic [15:0] crc;
    } t_stage;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/modbus_read_request_framer.sv =====
// top level of the modbus rtu read input registers request framer
//
// Request channel: i_req_valid / o_req_stall carry a start register and a
// register count; a transfer happens when valid is high and stall is low.
// Byte channel: o_byte_valid / i_byte_stall deliver the eight frame bytes
// (slave address, 0x04, start hi/lo, count hi/lo, crc lo, crc hi), with
// o_last_byte high on the crc high byte.
// Config channel: i_cfg_valid / o_cfg_ready write the slave address; it is
// always ready and should be written only while no frame is in flight.
// A request passes through three crc stages, two bytes each, then the
// output serializer, each registered, before its first byte is valid.
// The serializer sends one byte per cycle unless stalled and takes the
// next frame as the last byte goes out; up to three more requests wait.
// Reset clears all valid bits and sets the slave address to 2.
// When the receiver stalls, the current byte holds and the stall backs up
// through the stages to o_req_stall; nothing is lost or repeated.
module modbus_read_request_framer
    import mrrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic [15:0] i_start_register,
    input  logic [15:0] i_register_count,
    output logic        o_byte_valid,
    input  logic        i_byte_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_slave_addr;
    t_stage     w_s0_data;
    t_stage     w_s1_data;
    t_stage     w_s2_data;
    t_stage     w_s3_data;
    logic       w_s1_valid;
    logic       w_s2_valid;
    logic       w_s3_valid;
    logic       w_s1_stall;
    logic       w_s2_stall;
    logic       w_s3_stall;
    logic       w_ser_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slave_addr <= i_cfg_data;
        end
    end

    assign w_s0_data.hdr = {r_slave_addr, FUNC_READ_INPUT, i_start_register, i_register_count};
    assign w_s0_data.crc = CRC_INIT;
    assign o_req_stall   = w_s1_stall;

    mrrf_crc_stage u_stage1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req_valid),
        .o_stall   (w_s1_stall),
        .i_data    (w_s0_data),
        .i_byte_hi (w_s0_data.hdr[47:40]),
        .i_byte_lo (w_s0_data.hdr[39:32]),
        .o_valid   (w_s1_valid),
        .i_stall   (w_s2_stall),
        .o_data    (w_s1_data)
    );

    mrrf_crc_stage u_stage2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s1_valid),
        .o_stall   (w_s2_stall),
        .i_data    (w_s1_data),
        .i_byte_hi (w_s1_data.hdr[31:24]),
        .i_byte_lo (w_s1_data.hdr[23:16]),
        .o_valid   (w_s2_valid),
        .i_stall   (w_s3_stall),
        .o_data    (w_s2_data)
    );

    mrrf_crc_stage u_stage3 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s2_valid),
        .o_stall   (w_s3_stall),
        .i_data    (w_s2_data),
        .i_byte_hi (w_s2_data.hdr[15:8]),
        .i_byte_lo (w_s2_data.hdr[7:0]),
        .o_valid   (w_s3_valid),
        .i_stall   (w_ser_stall),
        .o_data    (w_s3_data)
    );

    mrrf_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_s3_valid),
        .o_stall      (w_ser_stall),
        .i_data       (w_s3_data),
        .o_valid      (o_byte_valid),
        .i_stall      (i_byte_stall),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    // a frame never breaks off before its last byte
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_valid && !i_byte_stall && !o_last_byte) |=> o_byte_valid)
        else $error("frame broke off before last byte");

    // a request transfer always lands in the first stage
    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> w_s1_valid)
        else $error("request transfer lost");

    // a config transfer updates the slave address
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_slave_addr == $past(i_cfg_data)))
        else $error("slave address not written");

    // the serializer only takes a new frame after the last byte goes out
    a_ser_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_valid && !o_last_byte) |-> w_ser_stall)
        else $error("serializer open mid frame");

endmodule

// ===== src/mrrf_crc_stage.sv =====
// one pipeline stage folding two header bytes into the running crc
module mrrf_crc_stage
    import mrrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_stage     i_data,
    input  logic [7:0] i_byte_hi,
    input  logic [7:0] i_byte_lo,
    output logic       o_valid,
    input  logic       i_stall,
    output t_stage     o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        n_data.hdr = i_data.hdr;
        n_data.crc = crc_byte(crc_byte(i_data.crc, i_byte_hi), i_byte_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/mrrf_serializer.sv =====
// holds a finished frame and sends it out one byte per transfer
module mrrf_serializer
    import mrrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_stage     i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic        r_valid;
    logic [2:0]  r_cnt;
    t_stage      r_data;
    logic [63:0] w_frame;
    logic [63:0] w_shifted;
    logic        w_last;

    assign w_last  = (r_cnt == LAST_IDX);
    assign o_stall = r_valid && !(w_last && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
            r_cnt   <= '0;
        end else if (r_valid && !i_stall) begin
            r_cnt   <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

    // crc goes out low byte first
    assign w_frame   = {r_data.hdr, r_data.crc[7:0], r_data.crc[15:8]};
    assign w_shifted = w_frame >> {3'(LAST_IDX - r_cnt), 3'b000};

    assign o_valid      = r_valid;
    assign o_frame_byte = w_shifted[7:0];
    assign o_last_byte  = w_last;

endmodule

// ===== verif/modbus_read_request_checker.sv =====
// checker that predicts the read request frames and compares every byte transfer
`timescale 1ns / 1ps

module modbus_read_request_checker
    import mrrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [15:0] i_start_register,
    input  logic [15:0] i_register_count,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending_bytes
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    t_frame_byte oldest;
    logic [7:0]  slave_addr;
    logic [47:0] header;
    logic [15:0] frame_crc;
    int          errors;

    function automatic logic [15:0] modbus_crc16(input logic [47:0] hdr);
        logic [15:0] acc;
        logic        fb;
        acc = CRC_INIT;
        for (int k = 5; k >= 0; k--) begin
            for (int b = 0; b < 8; b++) begin
                fb  = acc[0] ^ hdr[k*8 + b];
                acc = acc >> 1;
                if (fb) begin
                    acc = acc ^ CRC_POLY;
                end
            end
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slave_addr <= SLAVE_ADDR_RESET;
            expected_bytes.delete();
            o_pending_bytes <= 0;
            o_fail_count <= 0;
        end else begin
            errors = 0;
            if (i_cfg_valid && i_cfg_ready) begin
                slave_addr <= i_cfg_data;
            end
            // byte transfer is checked before this cycle's request is queued
            if (i_byte_valid && !i_byte_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected frame byte %02h (last %0b)",
                             $time, i_frame_byte, i_last_byte);
                    errors++;
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (i_frame_byte !== oldest.data) begin
                        $display("%0t: frame byte mismatch: expected %02h, actual %02h",
                                 $time, oldest.data, i_frame_byte);
                        errors++;
                    end
                    if (i_last_byte !== oldest.last) begin
                        $display("%0t: last byte mismatch: expected %0b, actual %0b",
                                 $time, oldest.last, i_last_byte);
                        errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                header    = {slave_addr, FUNC_READ_INPUT, i_start_register, i_register_count};
                frame_crc = modbus_crc16(header);
                for (int k = 5; k >= 0; k--) begin
                    expected_bytes.push_back('{data: header[k*8 +: 8], last: 1'b0});
                end
                expected_bytes.push_back('{data: frame_crc[7:0], last: 1'b0});
                expected_bytes.push_back('{data: frame_crc[15:8], last: 1'b1});
            end
            o_pending_bytes <= expected_bytes.size();
            o_fail_count <= o_fail_count + errors;
        end
    end

endmodule

// ===== verif/modbus_read_request_framer_tb.sv =====
// testbench top: clock, reset, request and config stimulus, verdict for the framer
`timescale 1ns / 1ps

module modbus_read_request_framer_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_stall;
    logic [15:0] i_start_register;
    logic [15:0] i_register_count;
    logic        o_byte_valid;
    logic        i_byte_stall;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          pending_bytes;
    bit          steady;
    logic [15:0] rnd_start;
    logic [15:0] rnd_count;

    modbus_read_request_framer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_stall      (o_req_stall),
        .i_start_register (i_start_register),
        .i_register_count (i_register_count),
        .o_byte_valid     (o_byte_valid),
        .i_byte_stall     (i_byte_stall),
        .o_frame_byte     (o_frame_byte),
        .o_last_byte      (o_last_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    modbus_read_request_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .i_req_stall      (o_req_stall),
        .i_start_register (i_start_register),
        .i_register_count (i_register_count),
        .i_byte_valid     (o_byte_valid),
        .i_byte_stall     (i_byte_stall),
        .i_frame_byte     (o_frame_byte),
        .i_last_byte      (o_last_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending_bytes  (pending_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 37);
    endfunction

    always @(posedge i_clk) begin
        i_byte_stall <= idle_now();
    end

    task automatic send_request(input logic [15:0] start, input logic [15:0] count);
        while (idle_now()) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid      <= 1'b1;
        i_start_register <= start;
        i_register_count <= count;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
    endtask

    task automatic write_slave_address(input logic [7:0] value);
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_req_valid      = 1'b0;
        i_start_register = '0;
        i_register_count = '0;
        i_byte_stall     = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        steady           = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset slave address, field extremes and out-of-range counts
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'd125);
        send_request(16'h0001, 16'd126);
        send_request(16'h1234, 16'h0010);
        send_request(16'hAAAA, 16'h5555);
        send_request(16'h5555, 16'hAAAA);

        write_slave_address(8'h00);
        send_request(16'h0000, 16'h0001);
        send_request(16'h8000, 16'h0080);
        send_request(16'h00FF, 16'hFF00);
        send_request(16'h7FFF, 16'h007D);

        write_slave_address(8'hFF);
        send_request(16'hFFFF, 16'h0001);
        send_request(16'h0100, 16'h0002);
        send_request(16'h0003, 16'h0000);
        send_request(16'hFEDC, 16'hBA98);

        for (int phase = 0; phase < 6; phase++) begin
            write_slave_address((phase == 5) ? 8'h01 : 8'($urandom));
            steady = (phase == 2);
            repeat (70) begin
                rnd_start = 16'($urandom);
                rnd_count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 130))
                                                        : 16'($urandom);
                if ($urandom_range(0, 15) == 0) begin
                    rnd_start = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                end
                send_request(rnd_start, rnd_count);
            end
        end
        steady = 1'b0;

        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
